/* sv/stsg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// stsg_pkg
// Shared types and constants for the scanline triangle span generator.
// ============================================================================
package stsg_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_UPPER = 2'd1,
        PH_LOWER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_WAIT1,
        SQ_WAIT2,
        SQ_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        EU_IDLE,
        EU_MUL,
        EU_DIV,
        EU_DONE
    } t_eu_state;

endpackage
`default_nettype wire

/* sv/stsg_sort.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// stsg_sort
// Orders three vertices by ascending y with three compare-and-swap steps.
// ============================================================================
module stsg_sort #(
    parameter int COORD_BITS = stsg_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    output logic signed [COORD_BITS-1:0] o_ax,
    output logic signed [COORD_BITS-1:0] o_ay,
    output logic signed [COORD_BITS-1:0] o_bx,
    output logic signed [COORD_BITS-1:0] o_by,
    output logic signed [COORD_BITS-1:0] o_cx,
    output logic signed [COORD_BITS-1:0] o_cy
);
    import stsg_pkg::*;

    logic signed [COORD_BITS-1:0] ax1, ay1, bx1, by1;
    logic signed [COORD_BITS-1:0] ax2, ay2, cx2, cy2;

    always_comb begin
        // (a,b)
        if (i_ay > i_by) begin
            ax1 = i_bx; ay1 = i_by; bx1 = i_ax; by1 = i_ay;
        end else begin
            ax1 = i_ax; ay1 = i_ay; bx1 = i_bx; by1 = i_by;
        end
        // (a,c)
        if (ay1 > i_cy) begin
            ax2 = i_cx; ay2 = i_cy; cx2 = ax1; cy2 = ay1;
        end else begin
            ax2 = ax1; ay2 = ay1; cx2 = i_cx; cy2 = i_cy;
        end
        // (b,c)
        o_ax = ax2;
        o_ay = ay2;
        if (by1 > cy2) begin
            o_bx = cx2; o_by = cy2; o_cx = bx1; o_cy = by1;
        end else begin
            o_bx = bx1; o_by = by1; o_cx = cx2; o_cy = cy2;
        end
    end

endmodule
`default_nettype wire

/* sv/stsg_edge_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// stsg_edge_unit
// Shared edge interpolator: base + (dx * dy) / den, truncated toward zero.
// A multiply step, then a restoring divide at one quotient bit per cycle.
// ============================================================================
module stsg_edge_unit #(
    parameter int COORD_BITS = stsg_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_base,
    input  logic signed [COORD_BITS:0]   i_dx,
    input  logic signed [COORD_BITS:0]   i_dy,
    input  logic        [COORD_BITS-1:0] i_den,
    output logic                         o_done,
    output logic signed [COORD_BITS-1:0] o_x
);
    import stsg_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PW    = 2 * CB;
    localparam int CNT_W = $clog2(CB);

    t_eu_state r_state, n_state;

    logic signed [CB-1:0] r_base, n_base;
    logic signed [CB:0]   r_dx, n_dx;
    logic signed [CB:0]   r_dy, n_dy;
    logic        [CB-1:0] r_den, n_den;
    logic        [PW-1:0] r_rem, n_rem;
    logic        [CB-1:0] r_quo, n_quo;
    logic                 r_neg, n_neg;
    logic     [CNT_W-1:0] r_cnt, n_cnt;

    logic signed [PW+1:0] w_prod;
    logic        [PW+1:0] w_abs;
    logic        [PW-1:0] w_den_sh;
    logic        [PW:0]   w_trial;
    logic        [CB-1:0] w_qs;

    assign w_prod   = r_dx * r_dy;
    assign w_abs    = w_prod[PW+1] ? -w_prod : w_prod;
    assign w_den_sh = PW'(r_den) << r_cnt;
    assign w_trial  = {1'b0, r_rem} - {1'b0, w_den_sh};
    assign w_qs     = r_neg ? -r_quo : r_quo;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            EU_IDLE, EU_DONE: begin
                n_state = i_start ? EU_MUL : EU_IDLE;
            end
            EU_MUL: begin
                n_state = EU_DIV;
            end
            EU_DIV: begin
                if (r_cnt == '0) n_state = EU_DONE;
            end
            default: n_state = EU_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == EU_DONE);
        o_x    = r_base + w_qs;
    end

    // datapath
    always_comb begin
        n_base = r_base;
        n_dx   = r_dx;
        n_dy   = r_dy;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        case (r_state)
            EU_IDLE, EU_DONE: begin
                if (i_start) begin
                    n_base = i_base;
                    n_dx   = i_dx;
                    n_dy   = i_dy;
                    n_den  = i_den;
                end
            end
            EU_MUL: begin
                n_rem = w_abs[PW-1:0];
                n_neg = w_prod[PW+1];
                n_quo = '0;
                n_cnt = CNT_W'(CB - 1);
            end
            EU_DIV: begin
                if (!w_trial[PW]) n_rem = w_trial[PW-1:0];
                n_quo = {r_quo[CB-2:0], !w_trial[PW]};
                n_cnt = r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
    end

endmodule
`default_nettype wire

/* sv/scanline_triangle_span_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// scanline_triangle_span_generator
// Sorts a triangle's vertices by y and emits one horizontal span per step.
//
//  channel  dir  handshake                    content
//  s_axis   in   s_axis_tvalid/s_axis_tready  start (vertices, colour) or step
//  m_axis   out  m_axis_tvalid/m_axis_tready  span (row, start, end, colour)
//
// A start transaction gives no span. A step transaction runs both edge
// divisions through one shared multiply/divide unit: the input is not ready
// again until both divisions are done and the span is in the output register.
// A step with no triangle in progress completes with no span.
// A held span waits in the output register; a finished step stalls there.
// Reset is synchronous and leaves the block idle with no triangle.
// ============================================================================
module scanline_triangle_span_generator #(
    parameter int COORD_BITS = stsg_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, fill_colour
    input  logic [((6*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // span_row, span_start, span_end, span_colour
    output logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_axis_tdata,
    // last_span
    output logic m_axis_tlast
);
    import stsg_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((3*COORD_BITS+32+7)/8)*8;

    t_seq_state r_seq, n_seq;
    t_phase     r_phase, n_phase;

    logic signed [CB-1:0] r_row, n_row;
    logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [CB-1:0] n_ax, n_ay, n_bx, n_by, n_cx, n_cy;
    logic        [31:0]   r_colour, n_colour;
    logic signed [CB-1:0] r_x1, n_x1;
    logic signed [CB-1:0] r_x2, n_x2;

    logic                 r_m_valid, n_m_valid;
    logic signed [CB-1:0] r_m_row, n_m_row;
    logic signed [CB-1:0] r_m_start, n_m_start;
    logic signed [CB-1:0] r_m_end, n_m_end;
    logic        [31:0]   r_m_colour, n_m_colour;
    logic                 r_m_last, n_m_last;

    logic signed [CB-1:0] w_in_ax, w_in_ay, w_in_bx, w_in_by, w_in_cx, w_in_cy;
    logic signed [CB-1:0] w_s_ax, w_s_ay, w_s_bx, w_s_by, w_s_cx, w_s_cy;
    logic        [31:0]   w_in_colour;

    logic w_in_acc;
    logic w_step_go;
    logic w_out_free;
    logic w_last;

    logic                 w_eu_start;
    logic                 w_eu_done;
    logic signed [CB-1:0] w_eu_x;
    logic signed [CB-1:0] w_eu_base;
    logic signed [CB:0]   w_eu_dx, w_eu_dy, w_eu_den;

    assign w_in_ax     = s_axis_tdata[CB-1:0];
    assign w_in_ay     = s_axis_tdata[2*CB-1:CB];
    assign w_in_bx     = s_axis_tdata[3*CB-1:2*CB];
    assign w_in_by     = s_axis_tdata[4*CB-1:3*CB];
    assign w_in_cx     = s_axis_tdata[5*CB-1:4*CB];
    assign w_in_cy     = s_axis_tdata[6*CB-1:5*CB];
    assign w_in_colour = s_axis_tdata[6*CB+31:6*CB];

    stsg_sort #(.COORD_BITS(CB)) u_sort (
        .i_ax(w_in_ax), .i_ay(w_in_ay),
        .i_bx(w_in_bx), .i_by(w_in_by),
        .i_cx(w_in_cx), .i_cy(w_in_cy),
        .o_ax(w_s_ax),  .o_ay(w_s_ay),
        .o_bx(w_s_bx),  .o_by(w_s_by),
        .o_cx(w_s_cx),  .o_cy(w_s_cy)
    );

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_step_go  = w_in_acc && (s_axis_tuser == FUNC_STEP) && (r_phase != PH_IDLE);
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_eu_start = w_step_go || ((r_seq == SQ_WAIT1) && w_eu_done);

    // edge operands: long edge a-c first, then a-b (upper) or b-c (lower)
    always_comb begin
        if (r_seq == SQ_WAIT1 && r_phase == PH_LOWER) begin
            w_eu_base = r_bx;
            w_eu_dx   = (CB+1)'(r_cx) - (CB+1)'(r_bx);
            w_eu_dy   = (CB+1)'(r_row) - (CB+1)'(r_by);
            w_eu_den  = (CB+1)'(r_cy) - (CB+1)'(r_by);
        end else if (r_seq == SQ_WAIT1) begin
            w_eu_base = r_ax;
            w_eu_dx   = (CB+1)'(r_bx) - (CB+1)'(r_ax);
            w_eu_dy   = (CB+1)'(r_row) - (CB+1)'(r_ay);
            w_eu_den  = (CB+1)'(r_by) - (CB+1)'(r_ay);
        end else begin
            w_eu_base = r_ax;
            w_eu_dx   = (CB+1)'(r_cx) - (CB+1)'(r_ax);
            w_eu_dy   = (CB+1)'(r_row) - (CB+1)'(r_ay);
            w_eu_den  = (CB+1)'(r_cy) - (CB+1)'(r_ay);
        end
    end

    stsg_edge_unit #(.COORD_BITS(CB)) u_edge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_eu_start),
        .i_base (w_eu_base),
        .i_dx   (w_eu_dx),
        .i_dy   (w_eu_dy),
        .i_den  (w_eu_den[CB-1:0]),
        .o_done (w_eu_done),
        .o_x    (w_eu_x)
    );

    // next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE:  if (w_step_go) n_seq = SQ_WAIT1;
            SQ_WAIT1: if (w_eu_done) n_seq = SQ_WAIT2;
            SQ_WAIT2: if (w_eu_done) n_seq = SQ_OUT;
            SQ_OUT:   if (w_out_free) n_seq = SQ_IDLE;
            default:  n_seq = SQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_seq == SQ_IDLE);
        m_axis_tvalid = r_m_valid;
        m_axis_tdata  = OUT_W'({r_m_colour, r_m_end, r_m_start, r_m_row});
        m_axis_tlast  = r_m_last;
    end

    // datapath
    always_comb begin
        n_phase    = r_phase;
        n_row      = r_row;
        n_ax       = r_ax;
        n_ay       = r_ay;
        n_bx       = r_bx;
        n_by       = r_by;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_colour   = r_colour;
        n_x1       = r_x1;
        n_x2       = r_x2;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_row    = r_m_row;
        n_m_start  = r_m_start;
        n_m_end    = r_m_end;
        n_m_colour = r_m_colour;
        n_m_last   = r_m_last;
        w_last     = 1'b0;
        case (r_seq)
            SQ_IDLE: begin
                if (w_in_acc && s_axis_tuser == FUNC_START) begin
                    n_ax     = w_s_ax;
                    n_ay     = w_s_ay;
                    n_bx     = w_s_bx;
                    n_by     = w_s_by;
                    n_cx     = w_s_cx;
                    n_cy     = w_s_cy;
                    n_colour = w_in_colour;
                    if (w_s_ay != w_s_by) begin
                        n_phase = PH_UPPER;
                        n_row   = w_s_ay;
                    end else if (w_s_by != w_s_cy) begin
                        n_phase = PH_LOWER;
                        n_row   = w_s_by;
                    end else begin
                        n_phase = PH_IDLE;
                        n_row   = '0;
                    end
                end
            end
            SQ_WAIT1: begin
                if (w_eu_done) n_x1 = w_eu_x;
            end
            SQ_WAIT2: begin
                if (w_eu_done) n_x2 = w_eu_x;
            end
            SQ_OUT: begin
                if (r_phase == PH_UPPER) begin
                    if (r_row >= r_by) begin
                        if (r_by != r_cy) begin
                            n_phase = PH_LOWER;
                            n_row   = r_by;
                        end else begin
                            n_phase = PH_IDLE;
                            w_last  = 1'b1;
                        end
                    end else begin
                        n_row = r_row + CB'(1);
                    end
                end else begin
                    if (r_row >= r_cy) begin
                        n_phase = PH_IDLE;
                        w_last  = 1'b1;
                    end else begin
                        n_row = r_row + CB'(1);
                    end
                end
                if (!w_out_free) begin
                    n_phase = r_phase;
                    n_row   = r_row;
                end else begin
                    n_m_valid  = 1'b1;
                    n_m_row    = r_row;
                    n_m_start  = (r_x1 < r_x2) ? r_x1 : r_x2;
                    n_m_end    = (r_x1 < r_x2) ? r_x2 : r_x1;
                    n_m_colour = r_colour;
                    n_m_last   = w_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SQ_IDLE;
            r_phase   <= PH_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_phase   <= n_phase;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_bx       <= n_bx;
        r_by       <= n_by;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_colour   <= n_colour;
        r_x1       <= n_x1;
        r_x2       <= n_x2;
        r_m_row    <= n_m_row;
        r_m_start  <= n_m_start;
        r_m_end    <= n_m_end;
        r_m_colour <= n_m_colour;
        r_m_last   <= n_m_last;
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eu_done |-> (r_seq == SQ_WAIT1 || r_seq == SQ_WAIT2))
        else $error("edge unit finished outside a wait state");

    a_upper_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UPPER) |-> (r_row >= r_ay && r_row <= r_by))
        else $error("upper half row out of range");

    a_lower_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOWER) |-> (r_row >= r_by && r_row <= r_cy))
        else $error("lower half row out of range");

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_OUT && w_out_free && w_last) |=> (r_phase == PH_IDLE))
        else $error("last span did not end the triangle");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the scanline triangle span generator. A queue-fed
// driver sends start and step transactions with random gaps; a monitor keeps
// a behavioral copy of the sorted triangle and row walk, predicts every span
// and compares the output stream field by field.
// ============================================================================
module tb_top;
    import stsg_pkg::*;

    localparam int CB    = COORD_BITS_DEF;
    localparam int IN_W  = ((6*CB+32+7)/8)*8;
    localparam int OUT_W = ((3*CB+32+7)/8)*8;
    localparam int STEP_LAT = 2*CB+6;

    typedef struct {
        logic                 func;
        logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
        logic [31:0]          colour;
    } t_tri_cmd;

    typedef struct {
        logic signed [CB-1:0] row, xs, xe;
        logic [31:0]          colour;
        logic                 last;
    } t_span;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    t_tri_cmd cmd_q[$];
    t_span    span_q[$];
    int       fail_cnt = 0;
    int       acc_cnt = 0;
    int       n_issued = 0;
    logic     in_taken = 1'b0;
    wire      steady = (acc_cnt >= 1200) && (acc_cnt < 1500);

    // predictor state
    int       tri_x[3] = '{0, 0, 0};
    int       tri_y[3] = '{0, 0, 0};
    int       walk_row = 0;
    t_phase   walk_phase = PH_IDLE;
    logic [31:0] tri_colour = '0;

    scanline_triangle_span_generator #(.COORD_BITS(CB)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sort on start, emit one span per step while a triangle is in progress
    function automatic void raster_step(input t_tri_cmd c, output bit got, output t_span sp);
        int x[3], yv[3], i, j, t, y, e1, e2;
        got = 1'b0;
        sp  = '{default: '0};
        if (c.func == FUNC_START) begin
            x  = '{int'(c.ax), int'(c.bx), int'(c.cx)};
            yv = '{int'(c.ay), int'(c.by), int'(c.cy)};
            for (int k = 0; k < 3; k++) begin
                i = (k == 2) ? 1 : 0;
                j = (k == 0) ? 1 : 2;
                if (yv[i] > yv[j]) begin
                    t = yv[i]; yv[i] = yv[j]; yv[j] = t;
                    t = x[i];  x[i]  = x[j];  x[j]  = t;
                end
            end
            tri_x = x;
            tri_y = yv;
            tri_colour = c.colour;
            if (yv[0] != yv[1]) begin
                walk_phase = PH_UPPER;
                walk_row = yv[0];
            end else if (yv[1] != yv[2]) begin
                walk_phase = PH_LOWER;
                walk_row = yv[1];
            end else begin
                walk_phase = PH_IDLE;
                walk_row = 0;
            end
            return;
        end
        if (walk_phase != PH_UPPER && walk_phase != PH_LOWER) return;
        y  = walk_row;
        e1 = tri_x[0] + ((tri_x[2] - tri_x[0]) * (y - tri_y[0])) / (tri_y[2] - tri_y[0]);
        if (walk_phase == PH_UPPER) begin
            e2 = tri_x[0] + ((tri_x[1] - tri_x[0]) * (y - tri_y[0])) / (tri_y[1] - tri_y[0]);
            if (y >= tri_y[1]) begin
                if (tri_y[1] != tri_y[2]) begin
                    walk_phase = PH_LOWER;
                    walk_row = tri_y[1];
                end else begin
                    walk_phase = PH_IDLE;
                    sp.last = 1'b1;
                end
            end else begin
                walk_row = y + 1;
            end
        end else begin
            e2 = tri_x[1] + ((tri_x[2] - tri_x[1]) * (y - tri_y[1])) / (tri_y[2] - tri_y[1]);
            if (y >= tri_y[2]) begin
                walk_phase = PH_IDLE;
                sp.last = 1'b1;
            end else begin
                walk_row = y + 1;
            end
        end
        sp.row    = y[CB-1:0];
        sp.xs     = (e1 < e2) ? e1[CB-1:0] : e2[CB-1:0];
        sp.xe     = (e1 < e2) ? e2[CB-1:0] : e1[CB-1:0];
        sp.colour = tri_colour;
        got = 1'b1;
    endfunction

    task automatic check_field(string fname, longint expv, longint actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, expv, actv);
            fail_cnt++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin : drv
        t_tri_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 27);
            if (!s_axis_tvalid || in_taken) begin
                if (cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
                    c = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= c.func;
                    s_axis_tdata  <= {c.colour, c.cy, c.cx, c.by, c.bx, c.ay, c.ax};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin : mon
        t_tri_cmd c;
        t_span    sp, e;
        bit       got;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (span_q.size() == 0) begin
                    $error("unexpected span transaction: row %0d",
                           $signed(m_axis_tdata[0 +: CB]));
                    fail_cnt++;
                end else begin
                    e = span_q.pop_front();
                    check_field("span_row", e.row, $signed(m_axis_tdata[0 +: CB]));
                    check_field("span_start", e.xs, $signed(m_axis_tdata[CB +: CB]));
                    check_field("span_end", e.xe, $signed(m_axis_tdata[2*CB +: CB]));
                    check_field("span_colour", e.colour, m_axis_tdata[3*CB +: 32]);
                    check_field("last_span", e.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                acc_cnt++;
                c.func   = s_axis_tuser;
                c.ax     = s_axis_tdata[0*CB +: CB];
                c.ay     = s_axis_tdata[1*CB +: CB];
                c.bx     = s_axis_tdata[2*CB +: CB];
                c.by     = s_axis_tdata[3*CB +: CB];
                c.cx     = s_axis_tdata[4*CB +: CB];
                c.cy     = s_axis_tdata[5*CB +: CB];
                c.colour = s_axis_tdata[6*CB +: 32];
                raster_step(c, got, sp);
                if (got) span_q.push_back(sp);
            end
        end
    end

    task automatic push_start(int ax, int ay, int bx, int by, int cx, int cy,
                              logic [31:0] col);
        t_tri_cmd c;
        c.func = FUNC_START;
        c.ax = ax[CB-1:0]; c.ay = ay[CB-1:0];
        c.bx = bx[CB-1:0]; c.by = by[CB-1:0];
        c.cx = cx[CB-1:0]; c.cy = cy[CB-1:0];
        c.colour = col;
        cmd_q.push_back(c);
        n_issued++;
    endtask

    // step payload is don't-care, so fill it with noise
    task automatic push_steps(int n);
        t_tri_cmd c;
        for (int i = 0; i < n; i++) begin
            c.func = FUNC_STEP;
            c.ax = CB'($urandom); c.ay = CB'($urandom); c.bx = CB'($urandom);
            c.by = CB'($urandom); c.cx = CB'($urandom); c.cy = CB'($urandom);
            c.colour = $urandom;
            cmd_q.push_back(c);
            n_issued++;
        end
    endtask

    task automatic gen_triangle(int h_max, int step_cap);
        int h, y0, ys[3], xv[3], lo, hi, mid, n, steps, r;
        h  = $urandom_range(0, h_max);
        y0 = int'($urandom_range(0, 4095 - h)) - 2048;
        for (int k = 0; k < 3; k++) begin
            ys[k] = y0 + int'($urandom_range(0, h));
            xv[k] = int'($urandom_range(0, 4095)) - 2048;
        end
        lo  = (ys[0] < ys[1]) ? ((ys[0] < ys[2]) ? ys[0] : ys[2])
                              : ((ys[1] < ys[2]) ? ys[1] : ys[2]);
        hi  = (ys[0] > ys[1]) ? ((ys[0] > ys[2]) ? ys[0] : ys[2])
                              : ((ys[1] > ys[2]) ? ys[1] : ys[2]);
        mid = ys[0] + ys[1] + ys[2] - lo - hi;
        n   = ((mid != lo) ? mid - lo + 1 : 0) + ((hi != mid) ? hi - mid + 1 : 0);
        r   = $urandom_range(0, 99);
        if (r < 10)      steps = $urandom_range(0, n);
        else if (r < 20) steps = n + $urandom_range(1, 3);
        else             steps = n;
        if (step_cap > 0 && steps > step_cap) steps = step_cap;
        push_start(xv[0], ys[0], xv[1], ys[1], xv[2], ys[2], $urandom);
        push_steps(steps);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || span_q.size() != 0);
    endtask

    task automatic fill_random(int target);
        int r;
        while (n_issued < target) begin
            r = $urandom_range(0, 99);
            if (r < 5)       push_steps($urandom_range(1, 3));
            else if (r < 7)  gen_triangle(4095, 10);
            else if (r < 20) gen_triangle(40, 0);
            else             gen_triangle(10, 0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_steps(1);                                          // step while idle
        push_start(4, 5, -7, 5, 9, 5, 32'h0000_0000);           // flat triangle
        push_steps(1);
        push_start(-2048, -2048, 2047, 0, 2047, 2047, 32'hFFFF_FFFF);
        push_steps(3);                                          // abandoned by next start
        push_start(0, 10, -5, 13, 7, 13, 32'hA5A5_5A5A);        // upper half only
        push_steps(5);
        push_start(3, 2047, -2, 2044, 9, 2044, 32'h1234_5678);  // lower half only
        push_steps(4);
        push_start(-3, 4, 0, 0, 4, 2, 32'h8000_0001);           // both halves, unsorted
        push_steps(6);
        wait_drained();
        repeat (STEP_LAT) @(posedge i_clk);

        fill_random(900);
        wait_drained();
        repeat (STEP_LAT) @(posedge i_clk);
        fill_random(1850);
        wait_drained();
        repeat (STEP_LAT + 10) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
